// ===== src/ade_pkg.sv =====
package ade_pkg;

    // Scan window length in bytes; bytes past it are ignored until the last byte
    localparam int WINDOW = 8192;
    localparam int POS_W  = $clog2(WINDOW + 1);

    localparam int HDR_LEN    = 7;
    localparam int FLEN_W     = 13;
    localparam int FRAMES_W   = 11;
    localparam int BYTES_W    = 14;
    localparam int RATE_W     = 17;
    localparam int SIZE_W     = 32;
    localparam int DUR_W      = 32;
    localparam int FILL_W     = 3;

    localparam int SPF_SHIFT  = 10;                       // 1024 samples per frame
    localparam int PROD_W     = SIZE_W + FRAMES_W;
    localparam int NUM_W      = PROD_W + SPF_SHIFT;
    localparam int DEN_W      = BYTES_W + RATE_W;
    localparam int DIV_STEPS  = NUM_W;
    localparam int DCNT_W     = $clog2(DIV_STEPS);

    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 64;

    localparam logic [7:0]          SYNC_BYTE    = 8'hFF;
    localparam logic [3:0]          SYNC_NIBBLE  = 4'hF;
    localparam logic [FRAMES_W-1:0] FRAMES_MAX   = '1;
    localparam logic [RATE_W-1:0]   DEFAULT_RATE = RATE_W'(48000);

    typedef enum logic [2:0] {
        ST_SCAN,
        ST_MUL,
        ST_INIT,
        ST_DIV,
        ST_LOAD
    } ade_state_t;

    typedef struct packed {
        logic take;       // consume one input byte
        logic size_load;  // capture file size with the last byte
        logic mul_load;   // register numerator and denominator products
        logic div_init;   // seed the divider
        logic div_step;   // one quotient bit
        logic out_load;   // publish result and clear scan state
    } ade_cmd_t;

    typedef struct packed {
        logic div_last;
        logic out_free;
    } ade_sts_t;

    // ADTS sampling frequency index; reserved codes return zero
    function automatic logic [RATE_W-1:0] rate_lookup(input logic [3:0] idx);
        logic [RATE_W-1:0] r;
        unique case (idx)
            4'd0:    r = RATE_W'(96000);
            4'd1:    r = RATE_W'(88200);
            4'd2:    r = RATE_W'(64000);
            4'd3:    r = RATE_W'(48000);
            4'd4:    r = RATE_W'(44100);
            4'd5:    r = RATE_W'(32000);
            4'd6:    r = RATE_W'(24000);
            4'd7:    r = RATE_W'(22050);
            4'd8:    r = RATE_W'(16000);
            4'd9:    r = RATE_W'(12000);
            4'd10:   r = RATE_W'(11025);
            4'd11:   r = RATE_W'(8000);
            4'd12:   r = RATE_W'(7350);
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ===== src/adts_duration_estimator.sv =====
// ADTS duration estimator. Stream the leading window of an AAC file in, one
// byte per transaction, and mark the final byte with tlast together with the
// total file size. While scanning, one byte is accepted every cycle. After the
// last byte the input stalls while the numerator (size * frames * 1024) and
// denominator (bytes * rate) products are registered, the divider is seeded,
// the bit-serial restoring divider runs, and the result is published once the
// previous result has been taken. The result reports whole seconds (saturated
// to 32 bits, zero when no complete frame was found), the frame count and the
// sample rate from the first header, and all scan state is then cleared for the
// next file.
module adts_duration_estimator
    import ade_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // data_byte[7:0], file_size[39:8]
    input  logic                 s_tlast,  // last_byte
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata   // duration_secs[31:0], frame_count[42:32],
                                           // sample_rate_hz[59:43], zero[63:60]
);

    ade_cmd_t cmd;
    ade_sts_t sts;

    ade_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ade_dpath u_dpath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .sts      (sts),
        .in_byte  (s_tdata[7:0]),
        .in_size  (s_tdata[39:8]),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata)
    );

endmodule

// ===== src/ade_ctrl.sv =====
module ade_ctrl
    import ade_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    input  logic     s_tlast,
    output logic     s_tready,
    input  ade_sts_t sts,
    output ade_cmd_t cmd
);

    ade_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_SCAN;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_SCAN: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.take = 1'b1;
                    if (s_tlast) begin
                        cmd.size_load = 1'b1;
                        state_next    = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                cmd.mul_load = 1'b1;
                state_next   = ST_INIT;
            end
            ST_INIT: begin
                cmd.div_init = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.div_last) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                // hold until the previous result has been taken
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_SCAN;
                end
            end
            default: state_next = ST_SCAN;
        endcase
    end

endmodule

// ===== src/ade_dpath.sv =====
module ade_dpath
    import ade_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ade_cmd_t             cmd,
    output ade_sts_t             sts,
    input  logic [7:0]           in_byte,
    input  logic [SIZE_W-1:0]    in_size,
    input  logic                 m_tready,
    output logic                 m_tvalid,
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam logic [POS_W-1:0]  WINDOW_L = POS_W'(WINDOW);
    localparam logic [FILL_W-1:0] FILL_HDR = FILL_W'(HDR_LEN);
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(HDR_LEN - 1);
    localparam logic [FLEN_W-1:0] FLEN_MIN = FLEN_W'(HDR_LEN);

    // scan state
    logic [7:0]          hdr_reg [HDR_LEN];
    logic [7:0]          hdr_next [HDR_LEN];
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic                in_frame_reg, in_frame_next;
    logic [FLEN_W-1:0]   skip_reg, skip_next;
    logic [FLEN_W-1:0]   pend_reg, pend_next;
    logic [FRAMES_W-1:0] frames_reg, frames_next;
    logic [BYTES_W-1:0]  bytes_reg, bytes_next;
    logic [RATE_W-1:0]   rate_reg, rate_next;
    logic                stopped_reg, stopped_next;
    logic [POS_W-1:0]    pos_reg, pos_next;

    // arithmetic
    logic [SIZE_W-1:0]   size_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [DEN_W-1:0]    den_reg;
    logic [NUM_W-1:0]    quo_reg;
    logic [DEN_W-1:0]    rem_reg;
    logic [DCNT_W-1:0]   dcnt_reg;
    logic                m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    logic [FILL_W-1:0]   fill_v;
    logic [FLEN_W-1:0]   flen;
    logic [FLEN_W-1:0]   pend_v;
    logic [FLEN_W-1:0]   skip_v;
    logic                hit;
    logic                count_v;
    logic [RATE_W-1:0]   rate_new;
    logic [DEN_W:0]      trial;
    logic                ge;
    logic [DUR_W-1:0]    duration;

    always_comb begin
        for (int i = 0; i < HDR_LEN; i++) begin
            hdr_next[i] = hdr_reg[i];
        end
        fill_next     = fill_reg;
        in_frame_next = in_frame_reg;
        skip_next     = skip_reg;
        pend_next     = pend_reg;
        frames_next   = frames_reg;
        bytes_next    = bytes_reg;
        rate_next     = rate_reg;
        stopped_next  = stopped_reg;
        pos_next      = pos_reg;
        fill_v        = '0;
        pend_v        = pend_reg;
        skip_v        = skip_reg;
        count_v       = 1'b0;
        hit           = 1'b0;
        rate_new      = rate_lookup(hdr_reg[3][5:2]);

        // header fields over the window with the new byte appended at the top
        flen = {hdr_reg[4][1:0], hdr_reg[5], hdr_reg[6][7:5]};

        if (cmd.out_load) begin
            fill_next     = '0;
            in_frame_next = 1'b0;
            skip_next     = '0;
            pend_next     = '0;
            frames_next   = '0;
            bytes_next    = '0;
            rate_next     = DEFAULT_RATE;
            stopped_next  = 1'b0;
            pos_next      = '0;
        end else if (cmd.take) begin
            if (!stopped_reg && (pos_reg < WINDOW_L)) begin
                pos_next = pos_reg + 1'b1;
                if (pos_next >= WINDOW_L) begin
                    stopped_next = 1'b1;
                end
                if (in_frame_reg) begin
                    if (skip_reg != '0) begin
                        skip_v = skip_reg - 1'b1;
                    end
                    skip_next = skip_v;
                    count_v   = (skip_v == '0);
                end else begin
                    for (int i = 0; i < HDR_LEN - 1; i++) begin
                        hdr_next[i] = hdr_reg[i+1];
                    end
                    hdr_next[HDR_LEN-1] = in_byte;
                    fill_v    = (fill_reg >= FILL_HDR) ? FILL_MAX : fill_reg;
                    fill_v    = fill_v + 1'b1;
                    fill_next = fill_v;
                    if (fill_v == FILL_HDR) begin
                        flen = {hdr_reg[4][1:0], hdr_reg[5], hdr_reg[6][7:5]};
                        hit  = (hdr_reg[1] == SYNC_BYTE)
                            && (hdr_reg[2][7:4] == SYNC_NIBBLE)
                            && (flen >= FLEN_MIN);
                        if (!hit) begin
                            // slide by one byte
                            fill_next = FILL_MAX;
                        end else begin
                            if ((frames_reg == '0) && (rate_new != '0)) begin
                                rate_next = rate_new;
                            end
                            pend_v        = flen;
                            pend_next     = flen;
                            skip_v        = flen - FLEN_MIN;
                            skip_next     = skip_v;
                            in_frame_next = 1'b1;
                            count_v       = (skip_v == '0);
                        end
                    end
                end
                if (count_v) begin
                    if (frames_reg < FRAMES_MAX) begin
                        frames_next = frames_reg + 1'b1;
                    end
                    bytes_next    = bytes_reg + BYTES_W'(pend_v);
                    in_frame_next = 1'b0;
                    fill_next     = '0;
                    pend_next     = '0;
                    skip_next     = '0;
                end
            end else begin
                stopped_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg     <= '0;
            in_frame_reg <= 1'b0;
            skip_reg     <= '0;
            pend_reg     <= '0;
            frames_reg   <= '0;
            bytes_reg    <= '0;
            rate_reg     <= DEFAULT_RATE;
            stopped_reg  <= 1'b0;
            pos_reg      <= '0;
        end else begin
            fill_reg     <= fill_next;
            in_frame_reg <= in_frame_next;
            skip_reg     <= skip_next;
            pend_reg     <= pend_next;
            frames_reg   <= frames_next;
            bytes_reg    <= bytes_next;
            rate_reg     <= rate_next;
            stopped_reg  <= stopped_next;
            pos_reg      <= pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < HDR_LEN; i++) begin
            hdr_reg[i] <= hdr_next[i];
        end
    end

    // restoring division, one quotient bit per cycle
    assign trial = {rem_reg, quo_reg[NUM_W-1]};
    assign ge    = (trial >= {1'b0, den_reg});

    always_ff @(posedge aclk) begin
        if (cmd.size_load) begin
            size_reg <= in_size;
        end
        if (cmd.mul_load) begin
            prod_reg <= PROD_W'(size_reg) * PROD_W'(frames_reg);
            den_reg  <= DEN_W'(bytes_reg) * DEN_W'(rate_reg);
        end
        if (cmd.div_init) begin
            quo_reg  <= {prod_reg, {SPF_SHIFT{1'b0}}};
            rem_reg  <= '0;
            dcnt_reg <= '0;
        end else if (cmd.div_step) begin
            quo_reg  <= {quo_reg[NUM_W-2:0], ge};
            rem_reg  <= ge ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
            dcnt_reg <= dcnt_reg + 1'b1;
        end
    end

    assign sts.div_last = (dcnt_reg == DCNT_W'(DIV_STEPS - 1));
    assign sts.out_free = !m_tvalid_reg || m_tready;

    // zero frames or zero bytes leave a zero denominator: report zero seconds
    always_comb begin
        if (den_reg == '0) begin
            duration = '0;
        end else if (quo_reg[NUM_W-1:DUR_W] != '0) begin
            duration = '1;
        end else begin
            duration = quo_reg[DUR_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_tdata_reg <= M_TDATA_W'({rate_reg, frames_reg, duration});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== src/ade_checker.sv =====
module ade_checker
    import ade_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [S_TDATA_W-1:0] s_tdata,
    input logic                 s_tlast,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // input stalls while the estimate is computed
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input accepted during estimate");

    // no counted frame means zero seconds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[42:32] == '0) |-> (m_tdata[31:0] == '0))
        else $error("nonzero duration without frames");

    // reported rate is never zero and padding stays clear
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[59:43] != '0) && (m_tdata[63:60] == '0))
        else $error("bad rate or padding in result");

endmodule

bind adts_duration_estimator ade_checker u_ade_checker (.*);

// ===== bench/ade_estimate_checker.sv =====
`timescale 1ns / 1ps

module ade_estimate_checker
    import ade_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tlast,
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_TDATA_W-1:0] m_tdata,
    output int                   fail_count,
    output int                   checked,
    output int                   awaiting
);

    localparam int PAD_LSB = DUR_W + FRAMES_W + RATE_W;

    // ADTS sampling frequency by index; the three reserved codes give zero
    localparam logic [RATE_W-1:0] RATE_BY_INDEX [16] = '{
        RATE_W'(96000), RATE_W'(88200), RATE_W'(64000), RATE_W'(48000),
        RATE_W'(44100), RATE_W'(32000), RATE_W'(24000), RATE_W'(22050),
        RATE_W'(16000), RATE_W'(12000), RATE_W'(11025), RATE_W'(8000),
        RATE_W'(7350), RATE_W'(0), RATE_W'(0), RATE_W'(0)
    };

    typedef struct packed {
        logic [DUR_W-1:0]    secs;
        logic [FRAMES_W-1:0] frames;
        logic [RATE_W-1:0]   rate;
    } estimate_t;

    estimate_t expected_estimates [$];

    // scan state of the predicted block
    logic [7:0]          hdr [HDR_LEN];
    logic [FILL_W-1:0]   hdr_fill;
    logic                skipping;
    logic [FLEN_W-1:0]   skip_left;
    logic [FLEN_W-1:0]   cur_len;
    logic [FRAMES_W-1:0] frames;
    logic [BYTES_W-1:0]  frame_bytes;
    logic [RATE_W-1:0]   rate;
    logic                scan_done;
    logic [POS_W-1:0]    pos;

    int errs;
    int n_checked;

    function automatic void clear_scan();
        hdr_fill    = '0;
        skipping    = 1'b0;
        skip_left   = '0;
        cur_len     = '0;
        frames      = '0;
        frame_bytes = '0;
        rate        = DEFAULT_RATE;
        scan_done   = 1'b0;
        pos         = '0;
    endfunction

    function automatic void close_frame();
        if (frames != FRAMES_MAX)
            frames++;
        frame_bytes = frame_bytes + BYTES_W'(cur_len);
        skipping    = 1'b0;
        hdr_fill    = '0;
        cur_len     = '0;
        skip_left   = '0;
    endfunction

    function automatic void scan_byte(input logic [7:0] b);
        logic [FLEN_W-1:0] flen;
        logic [RATE_W-1:0] r;
        if (skipping) begin
            if (skip_left != 0)
                skip_left--;
            if (skip_left == 0)
                close_frame();
            return;
        end
        if (hdr_fill >= HDR_LEN)
            hdr_fill = FILL_W'(HDR_LEN - 1);
        hdr[hdr_fill] = b;
        hdr_fill++;
        if (hdr_fill < HDR_LEN)
            return;
        flen = {hdr[3][1:0], hdr[4], hdr[5][7:5]};
        if (hdr[0] != SYNC_BYTE || hdr[1][7:4] != SYNC_NIBBLE || flen < HDR_LEN) begin
            // slide the candidate header by one byte
            for (int i = 0; i < HDR_LEN - 1; i++)
                hdr[i] = hdr[i + 1];
            hdr_fill = FILL_W'(HDR_LEN - 1);
            return;
        end
        // only a header seen before any complete frame sets the rate
        if (frames == 0) begin
            r = RATE_BY_INDEX[hdr[2][5:2]];
            if (r != 0)
                rate = r;
        end
        cur_len   = flen;
        skip_left = FLEN_W'(flen - HDR_LEN);
        skipping  = 1'b1;
        if (skip_left == 0)
            close_frame();
    endfunction

    function automatic logic [DUR_W-1:0] estimate_secs(input logic [SIZE_W-1:0] size);
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] q;
        if (frames == 0 || frame_bytes == 0 || rate == 0)
            return '0;
        num = 64'(size) * 64'(frames) * 64'd1024;
        den = 64'(frame_bytes) * 64'(rate);
        q = num / den;
        if (q > 64'hFFFF_FFFF)
            return '1;
        return q[DUR_W-1:0];
    endfunction

    function automatic void flag_mismatch(input string field, input logic [63:0] want,
                                          input logic [63:0] got);
        $display("%0t  %s mismatch: expected %0d, actual %0d", $time, field, want, got);
        errs++;
    endfunction

    always @(posedge aclk) begin
        estimate_t want;
        if (!aresetn) begin
            clear_scan();
            expected_estimates.delete();
            errs      = 0;
            n_checked = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                n_checked++;
                if (expected_estimates.size() == 0) begin
                    $display("%0t  unexpected estimate: expected none, actual %0h",
                             $time, m_tdata);
                    errs++;
                end else begin
                    want = expected_estimates.pop_front();
                    if (m_tdata[DUR_W-1:0] != want.secs)
                        flag_mismatch("duration_secs", want.secs, m_tdata[DUR_W-1:0]);
                    if (m_tdata[DUR_W +: FRAMES_W] != want.frames)
                        flag_mismatch("frame_count", want.frames, m_tdata[DUR_W +: FRAMES_W]);
                    if (m_tdata[DUR_W + FRAMES_W +: RATE_W] != want.rate)
                        flag_mismatch("sample_rate_hz", want.rate,
                                      m_tdata[DUR_W + FRAMES_W +: RATE_W]);
                    if (m_tdata[M_TDATA_W-1:PAD_LSB] != '0)
                        flag_mismatch("padding", 0, m_tdata[M_TDATA_W-1:PAD_LSB]);
                end
            end
            if (s_tvalid && s_tready) begin
                if (!scan_done && pos < WINDOW) begin
                    pos++;
                    if (pos >= WINDOW)
                        scan_done = 1'b1;
                    scan_byte(s_tdata[7:0]);
                end else begin
                    scan_done = 1'b1;
                end
                if (s_tlast) begin
                    want.secs   = estimate_secs(s_tdata[8 +: SIZE_W]);
                    want.frames = frames;
                    want.rate   = rate;
                    expected_estimates.push_back(want);
                    clear_scan();
                end
            end
        end
        fail_count <= errs;
        checked    <= n_checked;
        awaiting   <= expected_estimates.size();
    end

endmodule

// ===== bench/tb_adts_duration_estimator.sv =====
`timescale 1ns / 1ps

module tb_adts_duration_estimator;
    import ade_pkg::*;

    localparam int HOLD_CYCLES   = 400;
    localparam int STALL_LIMIT   = 5000;
    localparam int RANDOM_BYTES  = 1150;
    localparam int RANDOM_FILES  = 28;
    localparam int DRAIN_CYCLES  = 60;

    localparam logic [3:0] IDX_96000    = 4'd0;
    localparam logic [3:0] IDX_7350     = 4'd12;
    localparam logic [3:0] IDX_RESERVED = 4'd15;
    localparam logic [FLEN_W-1:0] LONG_FLEN = FLEN_W'(200);

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 s_tlast   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    int fail_count;
    int checked;
    int awaiting;

    logic [7:0] file_bytes [$];
    int files_sent        = 0;
    int bytes_sent        = 0;
    int bytes_past_window = 0;
    int tx_idle_pct       = 0;
    int rx_stall_pct      = 0;
    int quiet_cycles      = 0;
    int hold_left         = 0;
    bit hold_start        = 1'b0;
    bit hold_seen         = 1'b0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    adts_duration_estimator uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    ade_estimate_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (fail_count),
        .checked    (checked),
        .awaiting   (awaiting)
    );

    // result side: random stalls, plus a long hold-off whenever hold_start toggles
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_start != hold_seen) begin
            hold_seen <= hold_start;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic void add_noise(input int n);
        repeat (n) file_bytes.push_back(8'($urandom));
    endfunction

    // header with random side fields, then the payload that completes the frame
    function automatic void add_frame(input logic [3:0] idx, input logic [FLEN_W-1:0] flen);
        logic [7:0] r;
        file_bytes.push_back(SYNC_BYTE);
        file_bytes.push_back({SYNC_NIBBLE, 4'($urandom)});
        r = 8'($urandom);
        file_bytes.push_back({r[7:6], idx, r[1:0]});
        r = 8'($urandom);
        file_bytes.push_back({r[7:2], flen[12:11]});
        file_bytes.push_back(flen[10:3]);
        r = 8'($urandom);
        file_bytes.push_back({flen[2:0], r[4:0]});
        file_bytes.push_back(8'($urandom));
        for (int i = HDR_LEN; i < flen; i++)
            file_bytes.push_back(8'($urandom));
    endfunction

    function automatic logic [FLEN_W-1:0] random_len();
        if ($urandom_range(0, 9) != 0)
            return FLEN_W'($urandom_range(HDR_LEN, 24));
        return FLEN_W'($urandom_range(25, 120));
    endfunction

    function automatic void build_random_file();
        int kind;
        int shape;
        logic [FLEN_W-1:0] flen;
        kind = $urandom_range(0, 99);
        if (kind < 65) begin
            // well-formed frame run, sometimes with leading junk or a cut-off tail
            if ($urandom_range(0, 2) == 0)
                add_noise($urandom_range(1, 4));
            flen = random_len();
            repeat ($urandom_range(1, 3)) begin
                flen = random_len();
                add_frame(4'($urandom), flen);
            end
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, flen - 1)) void'(file_bytes.pop_back());
            else if ($urandom_range(0, 9) == 0)
                add_noise($urandom_range(1, 3));
        end else if (kind < 85) begin
            // broken headers: short length, bad sync nibble, bad sync byte
            repeat ($urandom_range(1, 3)) begin
                shape = $urandom_range(0, 2);
                if (shape == 0) begin
                    add_frame(4'($urandom), FLEN_W'($urandom_range(0, HDR_LEN - 1)));
                end else if (shape == 1) begin
                    file_bytes.push_back(SYNC_BYTE);
                    file_bytes.push_back(8'($urandom_range(0, 8'hEF)));
                    add_noise(5);
                end else begin
                    file_bytes.push_back(8'($urandom_range(0, 8'hFE)));
                    add_noise(6);
                end
                if ($urandom_range(0, 1) == 1)
                    add_frame(4'($urandom), random_len());
            end
        end else begin
            add_noise($urandom_range(1, 30));
        end
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic last,
                             input logic [SIZE_W-1:0] size);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {last ? size : SIZE_W'($urandom), b};
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic send_file(input logic [SIZE_W-1:0] size);
        int n;
        if (file_bytes.size() == 0)
            file_bytes.push_back(8'($urandom));
        n = file_bytes.size();
        for (int i = 0; i < n; i++)
            send_byte(file_bytes[i], i == n - 1, size);
        if (n > WINDOW)
            bytes_past_window += n - WINDOW;
        bytes_sent += n;
        files_sent++;
        file_bytes.delete();
    endtask

    task automatic wait_estimates();
        while (checked != files_sent) @(posedge aclk);
    endtask

    initial begin
        int file_no;
        int random_bytes;
        int phase;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed files: lone bytes, a shortest frame at the low end of the rate
        // table, a reserved rate index, and a top-rate frame cut off by the last byte
        file_bytes.push_back(8'h00);
        send_file('0);
        file_bytes.push_back(SYNC_BYTE);
        send_file('1);
        add_frame(IDX_7350, FLEN_W'(HDR_LEN));
        send_file('1);
        add_frame(IDX_RESERVED, FLEN_W'(HDR_LEN));
        send_file('0);
        add_frame(IDX_96000, FLEN_W'(HDR_LEN + 2));
        void'(file_bytes.pop_back());
        send_file(SIZE_W'($urandom));

        random_bytes = 0;
        file_no = 0;
        while (random_bytes < RANDOM_BYTES || file_no < RANDOM_FILES) begin
            if (file_no % 6 == 0) begin
                // drain before switching the idling mix
                s_tvalid <= 1'b0;
                wait_estimates();
                phase = (file_no / 6) % 4;
                tx_idle_pct  = (phase == 1) ? 74 : (phase == 3) ? 20 : 0;
                rx_stall_pct <= (phase == 2) ? 74 : (phase == 3) ? 20 : 0;
            end
            if (file_no == 3 || file_no == 27)
                hold_start <= ~hold_start;
            if (file_no == 20) begin
                // long frame, then trailing junk
                add_frame(4'($urandom), LONG_FLEN);
                add_noise(3);
            end else begin
                build_random_file();
            end
            random_bytes += (file_bytes.size() > WINDOW) ? WINDOW : file_bytes.size();
            send_file(SIZE_W'($urandom));
            file_no++;
        end
        s_tvalid <= 1'b0;

        wait_estimates();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Streamed %0d files, %0d bytes (%0d past the scan window), under four idling",
                 files_sent, bytes_sent, bytes_past_window);
        $display("mixes and two long output hold-offs; %0d estimates compared", checked);
        if (fail_count == 0 && awaiting == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
